/* src/periodic_tick_dispatcher_defines.svh */
// Assertion macros shared by the periodic tick dispatcher.
// Depends on nothing; included by the top level only.
`ifndef PERIODIC_TICK_DISPATCHER_DEFINES_SVH
`define PERIODIC_TICK_DISPATCHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PTD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define PTD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

/* src/ptd_pkg.sv */
// Shared types and codes for the periodic tick dispatcher.
// No dependencies.
package ptd_pkg;
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_REMOVE = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [2:0] KIND_FIRED     = 3'd0;
    localparam logic [2:0] KIND_INSERTED  = 3'd1;
    localparam logic [2:0] KIND_REMOVED   = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_FULL      = 3'd4;
    localparam logic [2:0] KIND_TICK_DONE = 3'd5;

    // Controller to datapath commands
    typedef struct packed {
        logic latch_req;   // capture input request
        logic set_idx;     // load job index from table count
        logic clr_idx;     // job index to zero
        logic inc_idx;     // job index + 1
        logic do_insert;   // write new job at end
        logic do_shift;    // move entry idx+1 down to idx, then idx+1
        logic dec_count;   // drop last entry
        logic div_start;   // start remainder of tick count by interval
        logic disable_job; // clear enable of entry idx
        logic inc_tick;    // advance tick count
    } ptd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic [1:0] action;
        logic       full;       // table holds the maximum number of jobs
        logic       idx_end;    // index reached table count
        logic       shift_end;  // idx+1 reached table count
        logic       id_match;   // entry idx id equals request id
        logic       div_busy;
        logic       hit;        // entry idx fires (valid after remainder done)
        logic       once;       // entry idx is run-once
    } ptd_stat_t;
endpackage

/* src/periodic_tick_dispatcher.sv */
// Periodic tick dispatcher: table of periodic jobs fired on each tick request.
// Channels: in_valid/in_ready carry action, handle_id, interval, offset, enable,
// run_once; out_valid/out_ready carry kind, fired_id, last.
// An insert answers inserted or table full from S_DEC once the output slot is free.
// A remove scans the table one entry a cycle while the output slot is free,
// then shifts the later entries up one a cycle.
// A tick runs a bit-serial remainder of the tick count by each job's interval,
// one job after another, and tests whether that job fires.
// Fired results come out in table order, then tick done with last set.
// One request is handled at a time; in_ready is high only between requests.
// Action 3 is accepted and gives no result.
// A stalled receiver holds the single output register; each result waits for it.
// Reset empties the table, clears the tick count and drops any pending result.
// Depends on ptd_pkg, ptd_ctrl, ptd_datapath, ptd_rem and the defines header.
`include "periodic_tick_dispatcher_defines.svh"
module periodic_tick_dispatcher #(
    parameter int JOB_SLOTS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [7:0]  handle_id,
    input  logic [31:0] interval,
    input  logic [31:0] offset,
    input  logic        enable,
    input  logic        run_once,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  fired_id,
    output logic        last
);
    import ptd_pkg::*;

    ptd_cmd_t   cmd;
    ptd_stat_t  stat;
    logic [7:0] req_id, cur_id;

    ptd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .fired_id  (fired_id),
        .last      (last),
        .cmd       (cmd),
        .stat      (stat),
        .req_id    (req_id),
        .cur_id    (cur_id)
    );

    ptd_datapath #(.JOB_SLOTS(JOB_SLOTS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .action    (action),
        .handle_id (handle_id),
        .interval  (interval),
        .offset    (offset),
        .enable    (enable),
        .run_once  (run_once),
        .stat      (stat),
        .req_id    (req_id),
        .cur_id    (cur_id)
    );

    // A fired result never carries last; every other kind does
    `PTD_ASSERT_IMPL(a_last_kind, clk, rst_n, out_valid, (last == (kind != KIND_FIRED)), "last flag does not match result kind")
    // Table never grows while full
    `PTD_ASSERT_IMPL(a_no_overfill, clk, rst_n, cmd.do_insert, !stat.full, "insert into full table")
    // A remainder is only started when the unit is idle
    `PTD_ASSERT_IMPL(a_div_idle, clk, rst_n, cmd.div_start, !stat.div_busy, "remainder restarted while busy")
    // Tick count only advances when tick done is produced
    `PTD_ASSERT_NEXT(a_tick_done, clk, rst_n, cmd.inc_tick, (out_valid && kind == KIND_TICK_DONE), "tick advanced without tick done")
endmodule

/* src/ptd_rem.sv */
// Serial remainder of a 64-bit dividend by a 32-bit divisor, one bit per cycle.
// Depends on nothing outside the module.
module ptd_rem (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic [31:0] rem
);
    logic [63:0] dvd_reg, dvd_next;
    logic [32:0] rem_reg, rem_next;
    logic [31:0] dsr_reg, dsr_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [32:0] trial;

    // Restoring step: shift in the next dividend bit, subtract when it fits
    always_comb
    begin
        dvd_next = dvd_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        cnt_next = cnt_reg;
        trial    = {rem_reg[31:0], dvd_reg[63]};
        if (start)
        begin
            dvd_next = dividend;
            rem_next = 33'd0;
            dsr_next = divisor;
            cnt_next = 7'd64;
        end
        else if (cnt_reg != 7'd0)
        begin
            dvd_next = {dvd_reg[62:0], 1'b0};
            if (trial >= {1'b0, dsr_reg})
                rem_next = trial - {1'b0, dsr_reg};
            else
                rem_next = trial;
            cnt_next = cnt_reg - 7'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= 7'd0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy = (cnt_reg != 7'd0);
    assign rem  = rem_reg[31:0];
endmodule

/* src/ptd_datapath.sv */
// Job table, tick counter and firing test for the tick dispatcher.
// Depends on ptd_pkg and ptd_rem.
module ptd_datapath #(
    parameter int JOB_SLOTS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ptd_pkg::ptd_cmd_t cmd,
    input  logic [1:0]        action,
    input  logic [7:0]        handle_id,
    input  logic [31:0]       interval,
    input  logic [31:0]       offset,
    input  logic              enable,
    input  logic              run_once,
    output ptd_pkg::ptd_stat_t stat,
    output logic [7:0]        req_id,
    output logic [7:0]        cur_id
);
    import ptd_pkg::*;

    localparam int IW = $clog2(JOB_SLOTS + 1);
    localparam int AW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;

    logic [1:0]  act_reg;
    logic [7:0]  hid_reg;
    logic [31:0] ivl_reg, ofs_reg;
    logic        en_reg, once_reg;
    logic [63:0] tick_reg;
    logic [IW-1:0] count_reg, idx_reg, idx_next, idx1;

    logic [7:0]  id_mem [JOB_SLOTS];
    logic [31:0] ivl_mem [JOB_SLOTS];
    logic [31:0] ofs_mem [JOB_SLOTS];
    logic        en_mem [JOB_SLOTS];
    logic        once_mem [JOB_SLOTS];

    logic [AW-1:0] ia, ia1, ca;
    logic          rem_busy;
    logic [31:0]   rem;

    assign idx1 = idx_reg + IW'(1);
    assign ia   = AW'(idx_reg);
    assign ia1  = AW'(idx1);
    assign ca   = AW'(count_reg);

    // Request capture
    always_ff @(posedge clk)
    begin
        if (cmd.latch_req)
        begin
            act_reg  <= action;
            hid_reg  <= handle_id;
            ivl_reg  <= interval;
            ofs_reg  <= offset;
            en_reg   <= enable;
            once_reg <= run_once;
        end
    end

    // Index, count and tick counter
    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.clr_idx)
            idx_next = '0;
        else if (cmd.set_idx)
            idx_next = count_reg;
        else if (cmd.inc_idx || cmd.do_shift)
            idx_next = idx1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg  <= 64'd0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (cmd.inc_tick)
                tick_reg <= tick_reg + 64'd1;
            if (cmd.do_insert)
                count_reg <= count_reg + IW'(1);
            else if (cmd.dec_count)
                count_reg <= count_reg - IW'(1);
        end
    end

    // Table writes
    always_ff @(posedge clk)
    begin
        if (cmd.do_insert)
        begin
            id_mem[ca]   <= hid_reg;
            ivl_mem[ca]  <= ivl_reg;
            ofs_mem[ca]  <= ofs_reg;
            en_mem[ca]   <= en_reg;
            once_mem[ca] <= once_reg;
        end
        else if (cmd.do_shift)
        begin
            id_mem[ia]   <= id_mem[ia1];
            ivl_mem[ia]  <= ivl_mem[ia1];
            ofs_mem[ia]  <= ofs_mem[ia1];
            en_mem[ia]   <= en_mem[ia1];
            once_mem[ia] <= once_mem[ia1];
        end
        else if (cmd.disable_job)
            en_mem[ia] <= 1'b0;
    end

    ptd_rem u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (tick_reg),
        .divisor  (ivl_mem[ia]),
        .busy     (rem_busy),
        .rem      (rem)
    );

    always_comb
    begin
        stat.action    = act_reg;
        stat.full      = (count_reg >= IW'(JOB_SLOTS));
        stat.idx_end   = (idx_reg >= count_reg);
        stat.shift_end = (idx1 >= count_reg);
        stat.id_match  = (id_mem[ia] == hid_reg);
        stat.div_busy  = rem_busy;
        stat.hit       = en_mem[ia] && (ivl_mem[ia] != 32'd0) && (rem == ofs_mem[ia]);
        stat.once      = once_mem[ia];
    end

    assign req_id = hid_reg;
    assign cur_id = id_mem[ia];
endmodule

/* src/ptd_ctrl.sv */
// Sequencer for the tick dispatcher: walks the table and issues results.
// Depends on ptd_pkg.
module ptd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         kind,
    output logic [7:0]         fired_id,
    output logic               last,
    output ptd_pkg::ptd_cmd_t  cmd,
    input  ptd_pkg::ptd_stat_t stat,
    input  logic [7:0]         req_id,
    input  logic [7:0]         cur_id
);
    import ptd_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DEC   = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIND  = 3'd4;
    localparam logic [2:0] S_SHIFT = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic [2:0] kind_reg, kind_next;
    logic [7:0] id_reg, id_next;
    logic       last_reg, last_next;
    logic       out_free;

    // Output slot is free when empty or being taken this cycle
    assign out_free = !ov_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        kind_next  = kind_reg;
        id_next    = id_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && action != ACT_NONE)
                begin
                    cmd.latch_req = 1'b1;
                    cmd.clr_idx   = 1'b1;
                    state_next    = S_DEC;
                end
            end
            S_DEC:
            begin
                unique case (stat.action)
                    ACT_TICK:   state_next = S_DIV;
                    ACT_INSERT:
                    begin
                        if (out_free)
                        begin
                            ov_next   = 1'b1;
                            id_next   = req_id;
                            last_next = 1'b1;
                            if (stat.full)
                                kind_next = KIND_FULL;
                            else
                            begin
                                kind_next     = KIND_INSERTED;
                                cmd.do_insert = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    default:    state_next = S_FIND;
                endcase
            end
            S_DIV:
            begin
                if (stat.idx_end)
                    state_next = S_OUT;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    if (!stat.hit)
                    begin
                        cmd.inc_idx = 1'b1;
                        state_next  = S_DIV;
                    end
                    else if (out_free)
                    begin
                        ov_next         = 1'b1;
                        kind_next       = KIND_FIRED;
                        id_next         = cur_id;
                        last_next       = 1'b0;
                        cmd.disable_job = stat.once;
                        cmd.inc_idx     = 1'b1;
                        state_next      = S_DIV;
                    end
                end
            end
            S_FIND:
            begin
                if (out_free)
                begin
                    if (stat.idx_end)
                    begin
                        ov_next    = 1'b1;
                        kind_next  = KIND_NOT_FOUND;
                        id_next    = req_id;
                        last_next  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else if (stat.id_match)
                        state_next = S_SHIFT;
                    else
                        cmd.inc_idx = 1'b1;
                end
            end
            S_SHIFT:
            begin
                if (stat.shift_end)
                begin
                    if (out_free)
                    begin
                        cmd.dec_count = 1'b1;
                        ov_next       = 1'b1;
                        kind_next     = KIND_REMOVED;
                        id_next       = req_id;
                        last_next     = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                    cmd.do_shift = 1'b1;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    cmd.inc_tick = 1'b1;
                    ov_next      = 1'b1;
                    kind_next    = KIND_TICK_DONE;
                    id_next      = 8'd0;
                    last_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        id_reg   <= id_next;
        last_reg <= last_next;
    end

    assign out_valid = ov_reg;
    assign kind      = kind_reg;
    assign fired_id  = id_reg;
    assign last      = last_reg;
endmodule
